/* hw/rtl/byte_stuffed_frame_receiver_core_macros.svh */
// Assertion macros used by the drain of the frame receiver RTL.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_CORE_MACROS_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BSFR_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

/* hw/rtl/bsfr_pkg.sv */
// Shared types and constants of the byte-stuffed frame receiver.
package bsfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 2'd2;

   localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd2;
   localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd16;

   // Buffer write from the front end
   typedef struct packed {
      logic              en;
      logic              bank;
      logic [LEN_W-1:0]  idx;
      logic [BYTE_W-1:0] data;
   } wr_type;

   // One finished frame waiting to be drained
   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
   } cmd_type;

   // One result word
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  frame_length;
      logic              last_of_frame;
   } out_type;

endpackage

/* hw/rtl/bsfr_req_if.sv */
// Input channel: one received byte per word.
interface bsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/bsfr_rsp_if.sv */
// Result channel: one payload byte of an accepted frame per word.
interface bsfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [5:0] frame_length;
   logic       last_of_frame;

   modport source (output valid, output payload_byte, output frame_length,
                   output last_of_frame, input ready);
   modport sink   (input valid, input payload_byte, input frame_length,
                   input last_of_frame, output ready);
endinterface

/* hw/rtl/byte_stuffed_frame_receiver_core.sv */
// Top level of the byte-stuffed frame receiver with XOR checksum.
// Usage:
//  - req_ch carries one received byte per word (valid/ready). Outside a frame
//    every byte but the start code is dropped; inside, the escape code makes
//    the next byte literal, the end code is followed by one checksum byte.
//  - rsp_ch returns, for a frame whose checksum (XOR of payload) matches and
//    whose payload is not empty, each payload byte in order with the frame
//    length and a last-of-frame flag on the final byte. Bad frames emit nothing.
//  - csr_wr_en/csr_index/csr_wr_data write start, end and escape codes
//    (indexes 0, 1, 2); other indexes are ignored. Write only while idle.
// Timing:
//  - Each input byte takes one cycle while req_ch.ready is high. The first
//    payload word passes the command queue, the read register and an output
//    slot after the checksum byte is accepted; the drain then moves one word
//    per cycle while rsp_ch takes words, set by the single buffer read port.
//  - The payload buffer has two banks: one frame drains while the next is
//    received. req_ch.ready drops while both banks hold frames not yet drained.
//  - A stalled rsp_ch holds its word; the drain stops after two queued words.
// Reset (synchronous, active high) returns to idle, restores the default
// codes (2, 3, 16) and empties all queues; buffer contents are not cleared.
module byte_stuffed_frame_receiver_core #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   bsfr_req_if.sink                       req_ch,
   bsfr_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsfr_pkg::BYTE_W-1:0]    csr_wr_data
);

   bsfr_pkg::wr_type  wr;
   bsfr_pkg::cmd_type cmd;
   bsfr_pkg::cmd_type head;
   logic              cmd_push;
   logic              q_pop;
   logic              q_valid;
   logic              q_full;

   // Classify bytes, track the checksum and fill the current bank.
   bsfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .q_full      (q_full),
      .wr          (wr),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   // Hold finished frames until the drain has read them out.
   bsfr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .head     (head)
   );

   // Read the frame out of its bank, one word per cycle while the output has room.
   bsfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .q_valid (q_valid),
      .head    (head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

/* hw/rtl/bsfr_front.sv */
// Front end: code registers, deframing state machine, checksum and buffer writes.
module bsfr_front #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsfr_pkg::BYTE_W-1:0]         csr_wr_data,
   bsfr_req_if.sink                            req_ch,
   input  logic                                q_full,
   output bsfr_pkg::wr_type                    wr,
   output logic                                cmd_push,
   output bsfr_pkg::cmd_type                   cmd
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_RECV = 4'b0010,
      PH_ESC  = 4'b0100,
      PH_CSUM = 4'b1000
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [bsfr_pkg::BYTE_W-1:0] xor_ff, xor_in;
   logic                        bank_ff, bank_in;
   logic [bsfr_pkg::BYTE_W-1:0] start_code_ff, end_code_ff, escape_code_ff;
   logic                        acc;
   logic                        do_store;
   logic [CW-1:0]               cnt_inc;
   logic [bsfr_pkg::BYTE_W-1:0] b;

   // Hold off input while both buffer banks are owned by pending frames.
   assign req_ch.ready = !q_full;
   assign acc          = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign cnt_inc      = count_ff + CW'(1);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      bank_in  = bank_ff;
      do_store = 1'b0;
      cmd_push = 1'b0;
      cmd.bank = bank_ff;
      cmd.len  = bsfr_pkg::LEN_W'(count_ff);
      wr.en    = 1'b0;
      wr.bank  = bank_ff;
      wr.idx   = bsfr_pkg::LEN_W'(count_ff);
      wr.data  = b;

      if (acc) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (b == start_code_ff) begin
                  phase_in = PH_RECV;
                  count_in = '0;
                  xor_in   = '0;
               end
            end
            PH_RECV: begin
               priority if (b == start_code_ff) begin
                  count_in = '0;
                  xor_in   = '0;
               end else if (b == end_code_ff) begin
                  phase_in = PH_CSUM;
               end else if (b == escape_code_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  do_store = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in = PH_RECV;
               do_store = 1'b1;
            end
            PH_CSUM: begin
               phase_in = PH_IDLE;
               if (b == xor_ff && count_ff != '0) begin
                  cmd_push = 1'b1;
                  bank_in  = !bank_ff;
               end else begin
                  count_in = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (do_store) begin
            wr.en = 1'b1;
            // Drop the frame once it fills the buffer.
            if (cnt_inc == CW'(BUFFER_DEPTH)) begin
               count_in = '0;
               xor_in   = '0;
               phase_in = PH_IDLE;
            end else begin
               count_in = cnt_inc;
               xor_in   = xor_ff ^ b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         count_ff       <= '0;
         xor_ff         <= '0;
         bank_ff        <= 1'b0;
         start_code_ff  <= bsfr_pkg::START_CODE_RST;
         end_code_ff    <= bsfr_pkg::END_CODE_RST;
         escape_code_ff <= bsfr_pkg::ESCAPE_CODE_RST;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         bank_ff  <= bank_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               bsfr_pkg::CSR_START_CODE:  start_code_ff  <= csr_wr_data;
               bsfr_pkg::CSR_END_CODE:    end_code_ff    <= csr_wr_data;
               bsfr_pkg::CSR_ESCAPE_CODE: escape_code_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

/* hw/rtl/bsfr_cmd_queue.sv */
// Two-entry queue of finished frames between front end and drain.
module bsfr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsfr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              q_valid,
   output logic              q_full,
   output bsfr_pkg::cmd_type head
);

   bsfr_pkg::cmd_type q_ff [2];
   logic              wptr_ff, rptr_ff;
   logic [1:0]        cnt_ff, cnt_in;

   assign q_valid = cnt_ff != 2'd0;
   assign q_full  = cnt_ff == 2'd2;
   assign head    = q_ff[rptr_ff];
   assign cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hw/rtl/bsfr_back.sv */
// Drain: two-bank payload buffer, read sequencer and output skid queue.
`include "byte_stuffed_frame_receiver_core_macros.svh"

module bsfr_back #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  bsfr_pkg::wr_type  wr,
   input  logic              q_valid,
   input  bsfr_pkg::cmd_type head,
   output logic              q_pop,
   bsfr_rsp_if.source        rsp_ch
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   // Each bank spans the full index range so {bank, idx} never runs past the end.
   logic [bsfr_pkg::BYTE_W-1:0] mem [2**(AW+1)];

   logic [bsfr_pkg::LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        rd_last;
   logic                        issue;
   logic [AW:0]                 rd_addr;
   logic [bsfr_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        pend_ff;
   logic [bsfr_pkg::LEN_W-1:0]  pend_len_ff;
   logic                        pend_last_ff;

   bsfr_pkg::out_type           out_ff [2];
   logic                        ohead_ff, otail_ff;
   logic [1:0]                  ocnt_ff, ocnt_in;
   logic [1:0]                  occ;
   logic                        out_pop;
   bsfr_pkg::out_type           out_head;

   assign rd_last = rd_idx_ff == (head.len - bsfr_pkg::LEN_W'(1));
   assign rd_addr = {head.bank, rd_idx_ff[AW-1:0]};

   // Keep reads in flight plus queued words within the two output slots.
   assign occ     = ocnt_ff + {1'b0, pend_ff};
   assign out_pop = rsp_ch.valid && rsp_ch.ready;
   assign issue   = q_valid && ((occ <= 2'd1) || out_pop);
   // Release the bank with its last read; the read data is already captured.
   assign q_pop   = issue && rd_last;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (issue) begin
         rd_idx_in = rd_last ? '0 : rd_idx_ff + bsfr_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
      end
      if (issue) begin
         rd_data_ff   <= mem[rd_addr];
         pend_len_ff  <= head.len;
         pend_last_ff <= rd_last;
      end
   end

   assign ocnt_in = ocnt_ff + {1'b0, pend_ff} - {1'b0, out_pop};

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_ff[otail_ff] <= '{payload_byte:  rd_data_ff,
                               frame_length:  pend_len_ff,
                               last_of_frame: pend_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
         ohead_ff  <= 1'b0;
         otail_ff  <= 1'b0;
         ocnt_ff   <= 2'd0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= issue;
         ocnt_ff   <= ocnt_in;
         if (pend_ff) otail_ff <= !otail_ff;
         if (out_pop) ohead_ff <= !ohead_ff;
      end
   end

   assign out_head             = out_ff[ohead_ff];
   assign rsp_ch.valid         = ocnt_ff != 2'd0;
   assign rsp_ch.payload_byte  = out_head.payload_byte;
   assign rsp_ch.frame_length  = out_head.frame_length;
   assign rsp_ch.last_of_frame = out_head.last_of_frame;

   `BSFR_ASSERT(a_issue_needs_frame, clock, reset, issue, q_valid)
   `BSFR_ASSERT(a_out_room, clock, reset, 1'b1, (3'(ocnt_ff) + 3'(pend_ff)) <= 3'd2)
   `BSFR_ASSERT_NEXT(a_last_rewinds, clock, reset, issue && rd_last, rd_idx_ff == '0)
   `BSFR_ASSERT(a_frame_not_empty, clock, reset, q_valid, head.len != '0)

endmodule

/* tb/sv/byte_stuffed_frame_receiver_core_test.sv */
// Self-checking testbench for the byte-stuffed frame receiver core.
module byte_stuffed_frame_receiver_core_test;

   localparam int BUFFER_DEPTH = 64;
   // Word slots the receiver keeps per frame; indexes wrap at this size.
   localparam int STORE_SLOTS = 64;
   // Cycles to let the core settle after the last expected payload word.
   localparam int DRAIN_SETTLE = 10;
   // Index past the last code register; writes to it must be dropped.
   localparam logic [bsfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef logic [bsfr_pkg::BYTE_W-1:0] rx_byte_type;
   typedef logic [bsfr_pkg::LEN_W-1:0] frame_len_type;
   typedef rx_byte_type byte_q_type[$];
   typedef enum logic [3:0] {
      RX_IDLE    = 4'b0001,
      RX_BODY    = 4'b0010,
      RX_ESCAPED = 4'b0100,
      RX_CHECK   = 4'b1000
   } rx_phase_type;

   // Mirror of the deframer: tracks codes, phase, payload and XOR, and holds
   // the payload words each good frame is going to produce.
   class deframe_scoreboard_type;
      rx_byte_type       start_code;
      rx_byte_type       end_code;
      rx_byte_type       escape_code;
      rx_phase_type      phase;
      logic [6:0]        stored;
      rx_byte_type       running_xor;
      rx_byte_type       held [STORE_SLOTS];
      bsfr_pkg::out_type payload_due[$];
      int unsigned       mismatches;

      function new();
         start_code  = bsfr_pkg::START_CODE_RST;
         end_code    = bsfr_pkg::END_CODE_RST;
         escape_code = bsfr_pkg::ESCAPE_CODE_RST;
         phase       = RX_IDLE;
         stored      = '0;
         running_xor = '0;
         mismatches  = 0;
      endfunction

      function int pending();
         return payload_due.size();
      endfunction

      function void write_code(logic [bsfr_pkg::CSR_IDX_W-1:0] idx, rx_byte_type value);
         unique case (idx)
            bsfr_pkg::CSR_START_CODE:  start_code  = value;
            bsfr_pkg::CSR_END_CODE:    end_code    = value;
            bsfr_pkg::CSR_ESCAPE_CODE: escape_code = value;
            default: ;
         endcase
      endfunction

      function void open_frame();
         phase       = RX_BODY;
         stored      = '0;
         running_xor = '0;
      endfunction

      // Store one payload byte; a full buffer throws the frame away.
      function void keep_byte(rx_byte_type b);
         held[stored[5:0]] = b;
         running_xor ^= b;
         stored = stored + 7'd1;
         if (stored >= BUFFER_DEPTH) begin
            stored      = '0;
            running_xor = '0;
            phase       = RX_IDLE;
         end
      endfunction

      function void note_rx_byte(rx_byte_type b);
         bsfr_pkg::out_type word;
         frame_len_type     len;
         unique case (phase)
            RX_BODY: begin
               // start beats end beats escape when codes coincide
               if (b == start_code) open_frame();
               else if (b == end_code) phase = RX_CHECK;
               else if (b == escape_code) phase = RX_ESCAPED;
               else keep_byte(b);
            end
            RX_ESCAPED: begin
               phase = RX_BODY;
               keep_byte(b);
            end
            RX_CHECK: begin
               phase = RX_IDLE;
               if (b == running_xor && stored != 0) begin
                  len = stored[5:0];
                  for (int k = 0; k < len; k++) begin
                     word.payload_byte  = held[k];
                     word.frame_length  = len;
                     word.last_of_frame = (k == len - 1);
                     payload_due.push_back(word);
                  end
               end else begin
                  stored = '0;
               end
            end
            default: begin
               if (b == start_code) open_frame();
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_payload_word(rx_byte_type b, frame_len_type len, logic last);
         bsfr_pkg::out_type want;
         if (payload_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word byte=%h len=%0d last=%b",
                                      b, len, last));
            return;
         end
         want = payload_due.pop_front();
         if (b !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %h, want %h", b, want.payload_byte));
         if (len !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d", len, want.frame_length));
         if (last !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame %b, want %b", last, want.last_of_frame));
      endtask
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en;
   logic [bsfr_pkg::CSR_IDX_W-1:0] csr_index;
   rx_byte_type                    csr_wr_data;

   bsfr_req_if req_ch ();
   bsfr_rsp_if rsp_ch ();

   deframe_scoreboard_type sb;
   int unsigned            fed;          // words accepted on req_ch so far
   bit                     steady_feed;  // hold req_ch.valid high with no gaps

   byte_stuffed_frame_receiver_core #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias payload toward the live codes so escaping gets exercised.
   function automatic rx_byte_type pick_payload_byte();
      unique case ($urandom_range(0, 9))
         0: return sb.start_code;
         1: return sb.end_code;
         2: return sb.escape_code;
         default: return rx_byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic byte_q_type random_body(int unsigned n);
      byte_q_type body;
      repeat (n) body.push_back(pick_payload_byte());
      return body;
   endfunction

   // Keep most frames short so the run stays quick; a few go long.
   function automatic int unsigned pick_frame_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 24);
      return $urandom_range(25, 62);
   endfunction

   // Present one byte and hold it until the core takes it. Valid is lowered
   // only when a gap follows, so back-to-back bytes never toggle it.
   task automatic send_byte(input rx_byte_type b);
      int unsigned gap;
      gap = steady_feed ? 0 : pause_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      // sample ready mid-cycle, where nothing else moves
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sb.note_rx_byte(b);
      fed++;
   endtask

   // Wrap a payload with start, escapes, end and its XOR checksum.
   task automatic send_frame(input byte_q_type body, input bit spoil_sum);
      rx_byte_type sum;
      sum = '0;
      send_byte(sb.start_code);
      foreach (body[i]) begin
         sum ^= body[i];
         if (body[i] == sb.start_code || body[i] == sb.end_code ||
             body[i] == sb.escape_code)
            send_byte(sb.escape_code);
         send_byte(body[i]);
      end
      send_byte(sb.end_code);
      if (spoil_sum) sum ^= rx_byte_type'(32'd1 << $urandom_range(0, 7));
      send_byte(sum);
   endtask

   // Drop valid, wait for every expected word, then let the core go quiet.
   task automatic settle_core();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // Load all three codes and poke the unused index; only while idle.
   task automatic write_codes(input rx_byte_type s, input rx_byte_type e,
                              input rx_byte_type x);
      rx_byte_type junk;
      junk = rx_byte_type'($urandom_range(0, 255));
      settle_core();
      csr_wr_en   <= 1'b1;
      csr_index   <= bsfr_pkg::CSR_START_CODE;
      csr_wr_data <= s;
      @(posedge clock);
      sb.write_code(bsfr_pkg::CSR_START_CODE, s);
      csr_index   <= bsfr_pkg::CSR_END_CODE;
      csr_wr_data <= e;
      @(posedge clock);
      sb.write_code(bsfr_pkg::CSR_END_CODE, e);
      csr_index   <= bsfr_pkg::CSR_ESCAPE_CODE;
      csr_wr_data <= x;
      @(posedge clock);
      sb.write_code(bsfr_pkg::CSR_ESCAPE_CODE, x);
      csr_index   <= CSR_SPARE_INDEX;
      csr_wr_data <= junk;
      @(posedge clock);
      sb.write_code(CSR_SPARE_INDEX, junk);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly good frames with random content, the rest bad
   // checksums, empty frames, restarts, cut-off frames, buffer overflows and line noise.
   task automatic run_mix(input int unsigned items);
      int unsigned goal;
      int unsigned kind;
      goal = fed + items;
      while (fed < goal) begin
         steady_feed = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            send_frame(random_body(pick_frame_len()), 1'b0);
         end else if (kind < 72) begin
            send_frame(random_body(pick_frame_len()), 1'b1);
         end else if (kind < 77) begin
            // empty payload; a zero checksum would match but must stay silent
            send_byte(sb.start_code);
            send_byte(sb.end_code);
            send_byte($urandom_range(0, 1) ? rx_byte_type'(0)
                                           : rx_byte_type'($urandom_range(0, 255)));
         end else if (kind < 83) begin
            send_byte(sb.start_code);
            repeat ($urandom_range(1, 4)) send_byte(pick_payload_byte());
            send_frame(random_body(pick_frame_len()), 1'b0);
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 5)) send_byte(rx_byte_type'($urandom_range(0, 255)));
         end else if (kind < 96) begin
            // frame cut short; whatever follows lands inside it
            send_byte(sb.start_code);
            repeat ($urandom_range(1, 8)) send_byte(pick_payload_byte());
         end else if (kind < 99) begin
            send_frame(random_body($urandom_range(55, BUFFER_DEPTH - 1)), 1'b0);
         end else begin
            send_frame(random_body(BUFFER_DEPTH), 1'b0);
         end
      end
      steady_feed = 1'b0;
   endtask

   // Check each payload word at the falling edge before the rising edge that takes it.
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_payload_word(rsp_ch.payload_byte, rsp_ch.frame_length,
                               rsp_ch.last_of_frame);
   end

   // Result side back-pressure: stall bursts between runs of ready.
   initial begin
      int unsigned hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = pause_len();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sb             = new();
      fed            = 0;
      steady_feed    = 1'b0;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= bsfr_pkg::CSR_START_CODE;
      csr_wr_data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, default codes. Drop bytes seen while idle.
      send_byte(8'h55);
      send_byte(8'hFF);
      // Field extremes plus every code carried as escaped payload.
      send_frame('{8'h00, 8'hFF, bsfr_pkg::START_CODE_RST, bsfr_pkg::ESCAPE_CODE_RST,
                   bsfr_pkg::END_CODE_RST}, 1'b0);
      // Empty payload with a matching zero checksum: no output.
      send_byte(bsfr_pkg::START_CODE_RST);
      send_byte(bsfr_pkg::END_CODE_RST);
      send_byte(8'h00);
      // Wrong checksum: no output.
      send_frame('{8'h41}, 1'b1);
      // Start code mid-frame restarts it; only the second payload counts.
      send_byte(bsfr_pkg::START_CODE_RST);
      send_byte(8'h11);
      send_frame('{8'h22}, 1'b0);

      run_mix(20);

      // Extreme code values; force the longest frame and a buffer overflow.
      write_codes(8'h00, 8'hFF, 8'h7D);
      send_frame(random_body(BUFFER_DEPTH - 1), 1'b0);
      send_frame(random_body(BUFFER_DEPTH), 1'b0);
      run_mix(50);

      write_codes(8'hFF, 8'h00, 8'h01);
      run_mix(50);

      // End code equals escape code: end wins, escaping is dead.
      write_codes(8'h7E, 8'h7D, 8'h7D);
      run_mix(25);

      // All codes equal: every code byte restarts the frame.
      write_codes(8'hAA, 8'hAA, 8'hAA);
      run_mix(15);

      write_codes(rx_byte_type'($urandom_range(0, 255)), rx_byte_type'($urandom_range(0, 255)),
                  rx_byte_type'($urandom_range(0, 255)));
      run_mix(40);

      write_codes(bsfr_pkg::START_CODE_RST, bsfr_pkg::END_CODE_RST,
                  bsfr_pkg::ESCAPE_CODE_RST);
      run_mix(30);

      settle_core();
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* byte_stuffed_frame_receiver_core.f */
+incdir+hw/rtl
hw/rtl/bsfr_pkg.sv
hw/rtl/bsfr_req_if.sv
hw/rtl/bsfr_rsp_if.sv
hw/rtl/bsfr_front.sv
hw/rtl/bsfr_cmd_queue.sv
hw/rtl/bsfr_back.sv
hw/rtl/byte_stuffed_frame_receiver_core.sv
tb/sv/byte_stuffed_frame_receiver_core_test.sv
